// ===== hdl/rrts_pkg.sv =====
// Shared constants, codes and controller/datapath types for the thread scheduler.
package rrts_pkg;

  localparam int MAX_THREADS = 16;
  localparam int ID_W        = $clog2(MAX_THREADS);
  localparam int CNT_W       = ID_W + 1;
  localparam int TICK_W      = 64;
  localparam int LOCK_W      = 8;

  localparam logic [ID_W-1:0]   IDLE_ID  = ID_W'(1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_THREADS);
  localparam logic [LOCK_W-1:0] LOCK_MAX = '1;

  // thread status codes
  localparam logic [1:0] ST_RUNNING  = 2'd0;
  localparam logic [1:0] ST_READY    = 2'd1;
  localparam logic [1:0] ST_SLEEPING = 2'd2;
  localparam logic [1:0] ST_BLOCKED  = 2'd3;

  // request codes
  localparam logic [2:0] REQ_WAKE     = 3'd0;
  localparam logic [2:0] REQ_SCHEDULE = 3'd1;
  localparam logic [2:0] REQ_BLOCK    = 3'd2;
  localparam logic [2:0] REQ_UNBLOCK  = 3'd3;
  localparam logic [2:0] REQ_SLEEP    = 3'd4;
  localparam logic [2:0] REQ_CREATE   = 3'd5;
  localparam logic [2:0] REQ_LOCK     = 3'd6;
  localparam logic [2:0] REQ_UNLOCK   = 3'd7;

  // error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_FULL      = 2'd1;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd2;

  // datapath commands, one per cycle
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SCAN_WAKE,
    CMD_SCAN_RM_TGT,
    CMD_SCAN_RM_CUR,
    CMD_SCAN_STEP,
    CMD_SCHED_START,
    CMD_SCHED_POP,
    CMD_PUSH_IDLE,
    CMD_SCHED_RUN,
    CMD_SCHED_REQUEUE,
    CMD_BLOCK,
    CMD_UNBLOCK,
    CMD_SLEEP_SET,
    CMD_CREATE,
    CMD_LOCK,
    CMD_UNLOCK_DEC,
    CMD_UNLOCK_CLR,
    CMD_OUT
  } cmd_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic [2:0] req;
    logic       lock_zero;
    logic       pending;
    logic       count_zero;
    logic       scan_last;
    logic       task_idle;
    logic       old_running;
    logic       tgt_waiting;
    logic       wake_past;
    logic       out_busy;
  } status_t;

endpackage

// ===== hdl/rrts_if.sv =====
// Request and response channel interfaces of the thread scheduler.
interface rrts_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [3:0]  target_thread;
  logic [63:0] wake_at;
  logic [63:0] now_ticks;
  logic [1:0]  block_kind;

  modport source (output valid, req_type, target_thread, wake_at, now_ticks, block_kind,
                  input ready);
  modport sink (input valid, req_type, target_thread, wake_at, now_ticks, block_kind,
                output ready);
endinterface

interface rrts_rsp_if;
  logic       valid;
  logic       ready;
  logic       switch_valid;
  logic [3:0] old_thread;
  logic [3:0] to_thread;
  logic [3:0] running_thread;
  logic [3:0] created_id;
  logic       irq_enabled;
  logic [1:0] error;

  modport source (output valid, switch_valid, old_thread, to_thread, running_thread,
                  created_id, irq_enabled, error, input ready);
  modport sink (input valid, switch_valid, old_thread, to_thread, running_thread,
                created_id, irq_enabled, error, output ready);
endinterface

// ===== hdl/rrts_ctrl.sv =====
// Sequencing state machine of the thread scheduler.
module rrts_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rrts_pkg::status_t st,
  output rrts_pkg::cmd_t   cmd
);
  import rrts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_SCHED0, S_SCHED1, S_PUSH_IDLE, S_SCHED2, S_SCHED3,
    S_UNBLK, S_SLEEP_SET, S_UNLOCK2, S_FINISH
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // next state and command
  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.req)
          REQ_WAKE: begin
            cmd        = CMD_SCAN_WAKE;
            state_next = S_SCAN;
          end
          REQ_SCHEDULE: state_next = S_SCHED0;
          REQ_BLOCK: begin
            cmd        = CMD_BLOCK;
            state_next = S_SCHED0;
          end
          REQ_UNBLOCK: begin
            if (st.tgt_waiting) begin
              cmd        = CMD_SCAN_RM_TGT;
              state_next = S_SCAN;
            end else begin
              state_next = S_FINISH;
            end
          end
          REQ_SLEEP: begin
            if (st.wake_past) begin
              state_next = S_FINISH;
            end else begin
              cmd        = CMD_SCAN_RM_CUR;
              state_next = S_SCAN;
            end
          end
          REQ_CREATE: begin
            cmd        = CMD_CREATE;
            state_next = S_FINISH;
          end
          REQ_LOCK: begin
            cmd        = CMD_LOCK;
            state_next = S_FINISH;
          end
          default: begin
            cmd        = CMD_UNLOCK_DEC;
            state_next = st.lock_zero ? S_FINISH : S_UNLOCK2;
          end
        endcase
      end
      S_SCAN: begin
        cmd = CMD_SCAN_STEP;
        if (st.scan_last) begin
          case (st.req)
            REQ_UNBLOCK: state_next = S_UNBLK;
            REQ_SLEEP:   state_next = S_SLEEP_SET;
            default:     state_next = S_FINISH;
          endcase
        end
      end
      S_UNBLK: begin
        cmd        = CMD_UNBLOCK;
        state_next = S_FINISH;
      end
      S_SLEEP_SET: begin
        cmd        = CMD_SLEEP_SET;
        state_next = S_SCHED0;
      end
      S_UNLOCK2: begin
        if (st.lock_zero && st.pending) begin
          cmd        = CMD_UNLOCK_CLR;
          state_next = S_SCHED0;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCHED0: begin
        cmd        = CMD_SCHED_START;
        state_next = (!st.lock_zero || st.count_zero) ? S_FINISH : S_SCHED1;
      end
      // idle thread at the head: skip it when others wait
      S_SCHED1: begin
        if (st.task_idle && !st.count_zero) begin
          cmd        = CMD_SCHED_POP;
          state_next = S_PUSH_IDLE;
        end else if (st.task_idle && st.old_running) begin
          cmd        = CMD_PUSH_IDLE;
          state_next = S_FINISH;
        end else begin
          state_next = S_SCHED2;
        end
      end
      S_PUSH_IDLE: begin
        cmd        = CMD_PUSH_IDLE;
        state_next = S_SCHED2;
      end
      S_SCHED2: begin
        cmd        = CMD_SCHED_RUN;
        state_next = S_SCHED3;
      end
      S_SCHED3: begin
        cmd        = CMD_SCHED_REQUEUE;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!st.out_busy) begin
          cmd        = CMD_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/rrts_datapath.sv =====
// Scheduler state, ready ring, sleep list and result register.
module rrts_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  rrts_pkg::cmd_t                cmd,
  output rrts_pkg::status_t             st,
  input  logic [2:0]                    req_type,
  input  logic [rrts_pkg::ID_W-1:0]     target_thread,
  input  logic [rrts_pkg::TICK_W-1:0]   wake_at,
  input  logic [rrts_pkg::TICK_W-1:0]   now_ticks,
  input  logic [1:0]                    block_kind,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          switch_valid,
  output logic [rrts_pkg::ID_W-1:0]     old_thread,
  output logic [rrts_pkg::ID_W-1:0]     to_thread,
  output logic [rrts_pkg::ID_W-1:0]     running_thread,
  output logic [rrts_pkg::ID_W-1:0]     created_id,
  output logic                          irq_enabled,
  output logic [1:0]                    error
);
  import rrts_pkg::*;

  // scheduler state
  logic [ID_W-1:0]   ready_ring [MAX_THREADS];
  logic [ID_W-1:0]   ready_head;
  logic [CNT_W-1:0]  ready_count;
  logic [1:0]        thread_state [MAX_THREADS];
  logic [TICK_W-1:0] wake_time [MAX_THREADS];
  logic [ID_W-1:0]   sleep_order [MAX_THREADS];
  logic [CNT_W-1:0]  sleep_count;
  logic [ID_W-1:0]   current_id;
  logic [LOCK_W-1:0] lock_depth;
  logic              switch_pending;
  logic [CNT_W-1:0]  next_id;

  // latched request
  logic [2:0]        q_req;
  logic [ID_W-1:0]   q_tgt;
  logic [TICK_W-1:0] q_wake;
  logic [TICK_W-1:0] q_now;
  logic [1:0]        q_kind;

  // working registers
  logic [ID_W-1:0]   old_id;
  logic [ID_W-1:0]   task_id;
  logic [CNT_W-1:0]  scan_i;
  logic [CNT_W-1:0]  scan_k;
  logic              scan_wake;
  logic [ID_W-1:0]   rm_id;

  // result of the request in flight
  logic              r_valid;
  logic [ID_W-1:0]   r_old;
  logic [ID_W-1:0]   r_new;
  logic [1:0]        r_err;
  logic [ID_W-1:0]   r_created;

  logic              scan_last;
  logic [ID_W-1:0]   scan_id;
  logic              scan_due;
  logic              push_en;
  logic [ID_W-1:0]   push_id;
  logic              pop_en;
  logic [ID_W-1:0]   tail;
  logic [CNT_W-1:0]  new_id;
  logic              preempt;

  assign scan_last = (scan_i >= sleep_count);
  assign scan_id   = sleep_order[scan_i[ID_W-1:0]];
  assign scan_due  = (wake_time[scan_id] <= q_now);
  assign tail      = ready_head + ready_count[ID_W-1:0];
  assign new_id    = next_id + CNT_W'(1);
  assign preempt   = (ready_count == '0) || (current_id == IDLE_ID);

  // status toward the controller
  always_comb begin
    st.req         = q_req;
    st.lock_zero   = (lock_depth == '0);
    st.pending     = switch_pending;
    st.count_zero  = (ready_count == '0);
    st.scan_last   = scan_last;
    st.task_idle   = (task_id == IDLE_ID);
    st.old_running = (thread_state[old_id] == ST_RUNNING);
    st.tgt_waiting = (thread_state[q_tgt] == ST_SLEEPING) ||
                     (thread_state[q_tgt] == ST_BLOCKED);
    st.wake_past   = (q_wake < q_now);
    st.out_busy    = out_valid && !out_ready;
  end

  // ready ring push and pop requests
  always_comb begin
    push_en = 1'b0;
    push_id = IDLE_ID;
    pop_en  = 1'b0;
    case (cmd)
      CMD_SCAN_STEP: begin
        push_en = !scan_last && scan_wake && scan_due;
        push_id = scan_id;
      end
      CMD_SCHED_START: pop_en = (lock_depth == '0) && (ready_count != '0);
      CMD_SCHED_POP:   pop_en = 1'b1;
      CMD_PUSH_IDLE:   push_en = 1'b1;
      CMD_SCHED_REQUEUE: begin
        push_en = (thread_state[old_id] == ST_RUNNING);
        push_id = old_id;
      end
      CMD_UNBLOCK: begin
        push_en = 1'b1;
        push_id = preempt ? current_id : q_tgt;
      end
      CMD_CREATE: begin
        push_en = (new_id < CNT_FULL) && (ready_count < CNT_FULL);
        push_id = new_id[ID_W-1:0];
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_head     <= '0;
      ready_count    <= CNT_W'(1);
      ready_ring[0]  <= IDLE_ID;
      for (int t = 0; t < MAX_THREADS; t++) begin
        thread_state[t] <= (ID_W'(t) == IDLE_ID) ? ST_READY : ST_RUNNING;
      end
      sleep_count    <= '0;
      current_id     <= '0;
      lock_depth     <= '0;
      switch_pending <= 1'b0;
      next_id        <= CNT_W'(1);
      out_valid      <= 1'b0;
    end else begin
      case (cmd)
        CMD_SCAN_STEP: begin
          if (scan_last) begin
            sleep_count <= scan_k;
          end else if (scan_wake && scan_due) begin
            thread_state[scan_id] <= ST_READY;
          end
        end
        CMD_SCHED_START: begin
          if (lock_depth != '0) begin
            switch_pending <= 1'b1;
          end
        end
        CMD_SCHED_RUN: begin
          thread_state[task_id] <= ST_RUNNING;
          current_id            <= task_id;
        end
        CMD_SCHED_REQUEUE: begin
          if (thread_state[old_id] == ST_RUNNING) begin
            thread_state[old_id] <= ST_READY;
          end
        end
        CMD_BLOCK: thread_state[current_id] <= q_kind;
        CMD_UNBLOCK: begin
          if (preempt) begin
            // a waiting current thread that gets unblocked ends up ready
            thread_state[current_id] <= ST_READY;
            if (q_tgt != current_id) begin
              thread_state[q_tgt] <= ST_RUNNING;
            end
            current_id <= q_tgt;
            if (lock_depth != '0) begin
              switch_pending <= 1'b1;
            end
          end else begin
            thread_state[q_tgt] <= ST_READY;
          end
        end
        CMD_SLEEP_SET: begin
          thread_state[current_id] <= ST_SLEEPING;
          if (sleep_count < CNT_FULL) begin
            sleep_count <= sleep_count + CNT_W'(1);
          end
        end
        CMD_CREATE: begin
          if (push_en) begin
            next_id                          <= new_id;
            thread_state[new_id[ID_W-1:0]] <= ST_READY;
          end
        end
        CMD_LOCK: begin
          if (lock_depth != LOCK_MAX) begin
            lock_depth <= lock_depth + LOCK_W'(1);
          end
        end
        CMD_UNLOCK_DEC: begin
          if (lock_depth != '0) begin
            lock_depth <= lock_depth - LOCK_W'(1);
          end
        end
        CMD_UNLOCK_CLR: switch_pending <= 1'b0;
        default: ;
      endcase

      // ring update: pop and push never share a cycle
      if (pop_en) begin
        ready_head  <= ready_head + ID_W'(1);
        ready_count <= ready_count - CNT_W'(1);
      end else if (push_en && (ready_count < CNT_FULL)) begin
        ready_ring[tail] <= push_id;
        ready_count      <= ready_count + CNT_W'(1);
      end

      // result beat
      if (cmd == CMD_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        q_req     <= req_type;
        q_tgt     <= target_thread;
        q_wake    <= wake_at;
        q_now     <= now_ticks;
        q_kind    <= (block_kind < ST_SLEEPING) ? ST_BLOCKED : block_kind;
        r_valid   <= 1'b0;
        r_old     <= '0;
        r_new     <= '0;
        r_err     <= ERR_OK;
        r_created <= '0;
      end
      CMD_SCAN_WAKE, CMD_SCAN_RM_TGT, CMD_SCAN_RM_CUR: begin
        scan_i    <= '0;
        scan_k    <= '0;
        scan_wake <= (cmd == CMD_SCAN_WAKE);
        rm_id     <= (cmd == CMD_SCAN_RM_TGT) ? q_tgt : current_id;
      end
      // keep an entry unless it wakes or is the one being removed
      CMD_SCAN_STEP: begin
        if (!scan_last) begin
          scan_i <= scan_i + CNT_W'(1);
          if (scan_wake ? !scan_due : (scan_id != rm_id)) begin
            sleep_order[scan_k[ID_W-1:0]] <= scan_id;
            scan_k                         <= scan_k + CNT_W'(1);
          end
        end
      end
      CMD_SCHED_START: begin
        old_id  <= current_id;
        task_id <= ready_ring[ready_head];
      end
      CMD_SCHED_POP: task_id <= ready_ring[ready_head];
      CMD_SCHED_REQUEUE: begin
        r_valid <= 1'b1;
        r_old   <= old_id;
        r_new   <= current_id;
      end
      CMD_UNBLOCK: begin
        if (preempt && (lock_depth == '0)) begin
          r_valid <= 1'b1;
          r_old   <= current_id;
          r_new   <= q_tgt;
        end
      end
      CMD_SLEEP_SET: begin
        wake_time[current_id] <= q_wake;
        if (sleep_count < CNT_FULL) begin
          sleep_order[sleep_count[ID_W-1:0]] <= current_id;
        end
      end
      CMD_CREATE: begin
        if (push_en) begin
          r_created <= new_id[ID_W-1:0];
        end else begin
          r_err <= ERR_FULL;
        end
      end
      CMD_UNLOCK_DEC: begin
        if (lock_depth == '0) begin
          r_err <= ERR_UNDERFLOW;
        end
      end
      CMD_OUT: begin
        switch_valid   <= r_valid;
        old_thread     <= r_old;
        to_thread      <= r_new;
        running_thread <= current_id;
        created_id     <= r_created;
        irq_enabled    <= (lock_depth == '0);
        error          <= r_err;
      end
      default: ;
    endcase
    // a push into a full ring flags the request
    if (push_en && (ready_count >= CNT_FULL) && (cmd != CMD_CREATE)) begin
      r_err <= ERR_FULL;
    end
  end

endmodule

// ===== hdl/round_robin_thread_scheduler_top.sv =====
// Top level of the round-robin thread scheduler.
//
// Requests arrive on the req channel (valid/ready); one result beat per
// request leaves on the rsp channel. The block handles one request at a
// time: req.ready is high only while it is idle.
// Paths from the accepted request to the result beat:
//   create, lock, unlock, no-op unblock, past-tick sleep: direct
//   schedule / block: pop, idle skip, requeue
//   unlock that takes a postponed switch: then the schedule steps
//   wake check, unblock, sleep: first the sleep list walk (up to 16
//   entries), one entry per cycle; sleep then schedules.
// The next request is taken once the block is back in idle after its
// result is registered; it is never taken while one is in flight.
// Reset (rst, synchronous) restores thread 0 running, the idle thread 1
// alone in the ready queue, an empty sleep list and no lock held.
// When the receiver stalls the result beat holds in the output register
// and the block waits with the next result until it is taken; the next
// request is accepted meanwhile and worked on up to that point.
module round_robin_thread_scheduler_top (
  input  logic       clk,
  input  logic       rst,
  rrts_req_if.sink   req,
  rrts_rsp_if.source rsp
);
  import rrts_pkg::*;

  cmd_t    cmd;
  status_t st;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  rrts_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .req_type       (req.req_type),
    .target_thread  (req.target_thread),
    .wake_at        (req.wake_at),
    .now_ticks      (req.now_ticks),
    .block_kind     (req.block_kind),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .switch_valid   (rsp.switch_valid),
    .old_thread     (rsp.old_thread),
    .to_thread      (rsp.to_thread),
    .running_thread (rsp.running_thread),
    .created_id     (rsp.created_id),
    .irq_enabled    (rsp.irq_enabled),
    .error          (rsp.error)
  );

endmodule

// ===== hdl/rrts_checker.sv =====
// Port-level checks of the thread scheduler, bound to the top level.
module rrts_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       switch_valid,
  input logic [3:0] old_thread,
  input logic [3:0] to_thread,
  input logic [3:0] running_thread,
  input logic [1:0] error
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(running_thread) && $stable(error))
    else $error("result beat changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // a switch lands on the running thread
  a_switch: assert property (@(posedge clk) disable iff (rst)
    out_valid && switch_valid |-> running_thread == to_thread)
    else $error("switch target is not the running thread");

  // no switch means zero thread fields
  a_noswitch: assert property (@(posedge clk) disable iff (rst)
    out_valid && !switch_valid |-> old_thread == 4'd0 && to_thread == 4'd0)
    else $error("thread fields set without a switch");

  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> error != 2'd3)
    else $error("undefined error code");

endmodule

bind round_robin_thread_scheduler_top rrts_checker u_rrts_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (req.valid),
  .in_ready       (req.ready),
  .out_valid      (rsp.valid),
  .out_ready      (rsp.ready),
  .switch_valid   (rsp.switch_valid),
  .old_thread     (rsp.old_thread),
  .to_thread      (rsp.to_thread),
  .running_thread (rsp.running_thread),
  .error          (rsp.error)
);
